// File: hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, control codes, command and state types.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = 16;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int IN_TDATA_W  = 24;
    localparam int IN_PAD_W    = IN_TDATA_W - CHAR_W - ROW_W - COL_W;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CELL_W - ROW_W - COL_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

    localparam logic [ATTR_W-1:0] TEXT_COLOR_RST   = 8'h0F;
    localparam logic [ATTR_W-1:0] CURSOR_COLOR_RST = 8'hFF;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic REG_TEXT_COLOR   = 1'b0;
    localparam logic REG_CURSOR_COLOR = 1'b1;

    typedef enum logic [2:0] {
        OP_READ,
        OP_CHAR,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIDE,
        ST_ACT,
        ST_COPY,
        ST_BLANK,
        ST_SHOW_RD,
        ST_SHOW_WR,
        ST_RD_DATA,
        ST_EMIT
    } t_state;

endpackage

// File: hdl/text_console_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit: character-cell text screen with block cursor
//
// Input channel s_axis: tuser is func (put / read), tdata carries char_code,
// read_row and read_col. Output channel m_axis: one item per input item,
// tdata carries cell_data, cursor_row and cursor_col, tuser is scrolled.
// i_cfg_we / i_cfg_addr / i_cfg_wdata write the text and cursor colors.
//
// A front stage decodes items into a two-entry queue; a sequencer executes
// them against a screen memory with one write and one read port.
// A put restores the cell under the cursor, acts on the screen, then reads
// and redraws the cursor cell; a scroll moves every row up and blanks the last.
// Items are executed one at a time; the front keeps accepting until the
// queue and its own register are full.
// After reset a clearing pass writes the blank screen with the cursor
// block at 0,0; s_axis_tready is low during it.
// A stalled m_axis holds its item; the next result waits in the sequencer
// and upstream items back up into the queue.
// ----------------------------------------------------------------------------
module text_console_writer_unit import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // char_code, read_row, read_col
    input  logic                   s_axis_tuser,   // func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // cell_data, cursor_row, cursor_col
    output logic                   m_axis_tuser,   // scrolled
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [ATTR_W-1:0]      i_cfg_wdata
);

    logic init_busy;
    logic f_vld;
    logic f_rdy;
    t_cmd f_cmd;
    logic q_vld;
    logic q_pop;
    t_cmd q_cmd;

    tcw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_init_busy   (init_busy),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_vld     (f_vld),
        .i_cmd_rdy     (f_rdy),
        .o_cmd         (f_cmd)
    );

    tcw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (f_vld),
        .o_push_rdy (f_rdy),
        .i_push_cmd (f_cmd),
        .o_pop_vld  (q_vld),
        .i_pop      (q_pop),
        .o_pop_cmd  (q_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_init_busy   (init_busy),
        .i_q_vld       (q_vld),
        .o_q_pop       (q_pop),
        .i_q_cmd       (q_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: hdl/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front: input stage
// Accepts items, decodes the byte into a command and holds it for the queue.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_init_busy,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // char_code, read_row, read_col
    input  logic                  s_axis_tuser,   // func
    output logic                  o_cmd_vld,
    input  logic                  i_cmd_rdy,
    output t_cmd                  o_cmd
);

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    assign s_axis_tready = (!r_vld || i_cmd_rdy) && !i_init_busy;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_cmd.char_code = s_axis_tdata[CHAR_W-1:0];
        n_cmd.read_row  = s_axis_tdata[CHAR_W +: ROW_W];
        n_cmd.read_col  = s_axis_tdata[CHAR_W+ROW_W +: COL_W];
        if (s_axis_tuser == FUNC_READ) begin
            n_cmd.op = OP_READ;
        end else begin
            unique case (n_cmd.char_code)
                CH_NEWLINE:   n_cmd.op = OP_NEWLINE;
                CH_RETURN:    n_cmd.op = OP_RETURN;
                CH_BACKSPACE: n_cmd.op = OP_BACKSPACE;
                default:      n_cmd.op = OP_CHAR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_cmd_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_vld = r_vld;
    assign o_cmd     = r_cmd;

endmodule

// File: hdl/tcw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue: command queue
// Short FIFO of decoded commands between the front and back parts.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_vld,
    output logic o_push_rdy,
    input  t_cmd i_push_cmd,
    output logic o_pop_vld,
    input  logic i_pop,
    output t_cmd o_pop_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_rdy = (r_count != NW'(QUEUE_DEPTH));
    assign o_pop_vld  = (r_count != '0);
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = i_pop && o_pop_vld;
    assign o_pop_cmd  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: hdl/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back: execution sequencer
// Owns the screen memory, cursor, colors and the result register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [ATTR_W-1:0]      i_cfg_wdata,
    output logic                   o_init_busy,
    input  logic                   i_q_vld,
    output logic                   o_q_pop,
    input  t_cmd                   i_q_cmd,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // cell_data, cursor_row, cursor_col
    output logic                   m_axis_tuser    // scrolled
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
    localparam logic [AW-1:0] COPY_N   = AW'(CELL_COUNT - COLUMNS);
    localparam logic [AW-1:0] LAST_IDX = AW'(CELL_COUNT - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [CELL_W-1:0] r_saved;
    logic [AW-1:0]     r_cnt;
    logic [AW-1:0]     r_dst;
    logic              r_rd_pend;
    logic              r_scroll;
    logic [CELL_W-1:0] r_data;
    logic [ATTR_W-1:0] r_text;
    logic [ATTR_W-1:0] r_cursor;
    logic              r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic              r_out_user;

    logic [RW-1:0]     n_row;
    logic [CW-1:0]     n_col;
    logic              n_scroll;
    logic [RW-1:0]     bs_row;
    logic [CW-1:0]     bs_col;
    logic              bs_move;
    logic [AW-1:0]     cur_idx;
    logic [AW-1:0]     bs_idx;
    logic [AW-1:0]     q_idx;
    logic              q_in_range;
    logic              emit_fire;
    logic [CELL_W-1:0] blank_cell;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    assign cur_idx    = AW'(r_row) * COLS_A + AW'(r_col);
    assign bs_idx     = AW'(bs_row) * COLS_A + AW'(bs_col);
    assign q_idx      = AW'(i_q_cmd.read_row) * COLS_A + AW'(i_q_cmd.read_col);
    assign q_in_range = (int'(i_q_cmd.read_row) < ROWS) && (int'(i_q_cmd.read_col) < COLUMNS);
    assign blank_cell = {r_text, SPACE_CHAR};
    assign emit_fire  = (r_state == ST_EMIT) && (!r_out_vld || m_axis_tready);

    // cursor motion of a put
    always_comb begin
        bs_row   = r_row;
        bs_col   = r_col;
        bs_move  = 1'b0;
        n_row    = r_row;
        n_col    = r_col;
        n_scroll = 1'b0;
        if (r_col != '0) begin
            bs_col  = r_col - 1'b1;
            bs_move = 1'b1;
        end else if (r_row != '0) begin
            bs_row  = r_row - 1'b1;
            bs_col  = LAST_COL;
            bs_move = 1'b1;
        end
        case (r_cmd.op)
            OP_CHAR: begin
                if (r_col == LAST_COL) begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        n_scroll = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            OP_NEWLINE: begin
                n_col = '0;
                if (r_row == LAST_ROW) begin
                    n_scroll = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            OP_RETURN: begin
                n_col = '0;
            end
            OP_BACKSPACE: begin
                n_row = bs_row;
                n_col = bs_col;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_vld) begin
                    if (i_q_cmd.op == OP_READ) begin
                        n_state = q_in_range ? ST_RD_DATA : ST_EMIT;
                    end else begin
                        n_state = ST_HIDE;
                    end
                end
            end
            ST_HIDE:    n_state = ST_ACT;
            ST_ACT:     n_state = n_scroll ? ST_COPY : ST_SHOW_RD;
            ST_COPY: begin
                if (r_cnt == COPY_N) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_SHOW_RD;
                end
            end
            ST_SHOW_RD: n_state = ST_SHOW_WR;
            ST_SHOW_WR: n_state = ST_EMIT;
            ST_RD_DATA: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_idx;
        mem_wdata = r_saved;
        mem_re    = 1'b0;
        mem_raddr = cur_idx;
        o_q_pop   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = (r_cnt == '0) ? {CURSOR_COLOR_RST, SPACE_CHAR}
                                          : {TEXT_COLOR_RST, SPACE_CHAR};
            end
            ST_IDLE: begin
                o_q_pop   = i_q_vld;
                mem_re    = i_q_vld && (i_q_cmd.op == OP_READ) && q_in_range;
                mem_raddr = q_idx;
            end
            ST_HIDE: begin
                mem_we = 1'b1;
            end
            ST_ACT: begin
                if (r_cmd.op == OP_CHAR) begin
                    mem_we    = 1'b1;
                    mem_wdata = {r_text, r_cmd.char_code};
                end else if (r_cmd.op == OP_BACKSPACE && bs_move) begin
                    mem_we    = 1'b1;
                    mem_waddr = bs_idx;
                    mem_wdata = blank_cell;
                end
            end
            ST_COPY: begin
                // read one row ahead, write the word fetched last cycle
                mem_we    = r_rd_pend;
                mem_waddr = r_dst;
                mem_wdata = r_rdata;
                mem_re    = (r_cnt != COPY_N);
                mem_raddr = r_cnt + COLS_A;
            end
            ST_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = blank_cell;
            end
            ST_SHOW_RD: begin
                mem_re = 1'b1;
            end
            ST_SHOW_WR: begin
                mem_we    = 1'b1;
                mem_wdata = {r_cursor, SPACE_CHAR};
            end
            ST_RD_DATA, ST_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_rd_pend <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_saved   <= {TEXT_COLOR_RST, SPACE_CHAR};
            r_text    <= TEXT_COLOR_RST;
            r_cursor  <= CURSOR_COLOR_RST;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_TEXT_COLOR) begin
                    r_text <= i_cfg_wdata;
                end else begin
                    r_cursor <= i_cfg_wdata;
                end
            end
            case (r_state)
                ST_CLEAR, ST_BLANK: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_ACT: begin
                    r_row     <= n_row;
                    r_col     <= n_col;
                    r_cnt     <= '0;
                    r_rd_pend <= 1'b0;
                end
                ST_COPY: begin
                    r_rd_pend <= (r_cnt != COPY_N);
                    if (r_cnt != COPY_N) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SHOW_WR: begin
                    r_saved <= r_rdata;
                end
                default: ;
            endcase
            if (emit_fire) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_vld) begin
            r_cmd    <= i_q_cmd;
            r_data   <= '0;
            r_scroll <= 1'b0;
        end
        if (r_state == ST_ACT) begin
            r_scroll <= n_scroll;
        end
        if (r_state == ST_COPY) begin
            r_dst <= r_cnt;
        end
        if (r_state == ST_RD_DATA) begin
            r_data <= r_rdata;
        end
        if (emit_fire) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, COL_W'(r_col), ROW_W'(r_row), r_data};
            r_out_user <= r_scroll;
        end
    end

    assign o_init_busy   = (r_state == ST_CLEAR);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// File: hdl/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // cursor always on screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (int'(m_axis_tdata[CELL_W +: ROW_W]) < ROWS) &&
                          (int'(m_axis_tdata[CELL_W+ROW_W +: COL_W]) < COLUMNS))
        else $error("cursor off screen");

    // a scroll leaves the cursor at the start of the bottom row, with zero cell data
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (int'(m_axis_tdata[CELL_W +: ROW_W]) == ROWS - 1) &&
            (m_axis_tdata[CELL_W+ROW_W +: COL_W] == '0) &&
            (m_axis_tdata[CELL_W-1:0] == '0))
        else $error("scroll with wrong cursor or data");

    // no input taken right after reset while the screen is being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
